// ===== hdl/itoa_pkg.sv =====
// Package for the integer to ASCII radix converter.
// Holds shared widths, radix limits, character codes and the digit encoder.
// No dependencies.
package itoa_pkg;

  localparam int VALUE_WIDTH_DEF = 32;
  localparam int RADIX_W         = 6;
  localparam int CHAR_W          = 8;
  // Quotient bits retired per divider cycle; each step is a 7-bit compare and subtract.
  localparam int STEP_BITS       = 8;

  localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
  localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;

  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_LOWA  = 8'h61;

  // Maps a digit value 0..35 to '0'-'9' or 'a'-'z'.
  function automatic logic [CHAR_W-1:0] digit_char(input logic [RADIX_W-1:0] d);
    logic [CHAR_W-1:0] dx;
    dx = {2'b00, d};
    if (d < 6'd10) begin
      return CHAR_ZERO + dx;
    end else begin
      return CHAR_LOWA + dx - 8'd10;
    end
  endfunction

endpackage

// ===== hdl/itoa_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Used for the digit buffer of the converter; depends on nothing.
module itoa_ram #(
  parameter int WIDTH = 6,
  parameter int DEPTH = 32
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/itoa_div.sv =====
// Iterative divider of an unsigned word by a radix of up to 6 bits.
// Produces STEP_BITS quotient bits per cycle; uses itoa_pkg.
module itoa_div #(
  parameter int DIV_W = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [DIV_W-1:0]                dividend_i,
  input  logic [itoa_pkg::RADIX_W-1:0]    divisor_i,
  output logic                            done_o,
  output logic [DIV_W-1:0]                quotient_o,
  output logic [itoa_pkg::RADIX_W-1:0]    remainder_o
);

  localparam int SB    = itoa_pkg::STEP_BITS;
  localparam int RW    = itoa_pkg::RADIX_W;
  localparam int NCYC  = DIV_W / SB;
  localparam int CNT_W = (NCYC > 1) ? $clog2(NCYC) : 1;

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [DIV_W-1:0] quo_q;
  logic [RW-1:0]    rem_q;
  logic [RW-1:0]    div_q;

  logic [DIV_W-1:0] quo_v;
  logic [RW-1:0]    rem_v;
  logic [RW:0]      wide_v;

  // Restoring division, SB bits per cycle. The partial remainder is below
  // twice the divisor, so it fits RW+1 bits before the subtract.
  always_comb begin
    quo_v  = quo_q;
    rem_v  = rem_q;
    wide_v = '0;
    for (int s = 0; s < SB; s++) begin
      wide_v = {rem_v, quo_v[DIV_W-1]};
      quo_v  = {quo_v[DIV_W-2:0], 1'b0};
      if (wide_v >= {1'b0, div_q}) begin
        wide_v   = wide_v - {1'b0, div_q};
        quo_v[0] = 1'b1;
      end
      rem_v = wide_v[RW-1:0];
    end
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(NCYC - 1);
    end else if (busy_q) begin
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      div_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= quo_v;
      rem_q <= rem_v;
    end
  end

  assign done_o      = done_q;
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

endmodule

// ===== hdl/integer_to_ascii_radix_core.sv =====
// Integer to ASCII text converter, top level.
// Depends on itoa_pkg, itoa_div and itoa_ram.
//
// Converts one signed VALUE_WIDTH-bit word into its text in the radix held in
// the configuration register (reset 10), one ASCII byte per output word, most
// significant first: an optional '-', lower-case digits, then a zero byte with
// last set. A radix outside 2 to 36 gives only the zero byte. Digits come out
// of one shared divider that retires 8 quotient bits per cycle, one division
// per digit; the digits are buffered in a small RAM and replayed, each
// character read in S_RD and sent in S_WR, which waits while the output is
// stalled. The input is ready only between words; the last output word may
// still be waiting when the next input word is taken.
module integer_to_ascii_radix_core #(
  parameter int VALUE_WIDTH = itoa_pkg::VALUE_WIDTH_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [itoa_pkg::RADIX_W-1:0]       radix_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic signed [VALUE_WIDTH-1:0]      value_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [itoa_pkg::CHAR_W-1:0]        char_out_o,
  output logic                               last_o
);

  localparam int RW    = itoa_pkg::RADIX_W;
  localparam int CW    = itoa_pkg::CHAR_W;
  localparam int SB    = itoa_pkg::STEP_BITS;
  localparam int DIV_W = ((VALUE_WIDTH + SB - 1) / SB) * SB;
  localparam int AW    = $clog2(VALUE_WIDTH);
  localparam int NDW   = $clog2(VALUE_WIDTH + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIV  = 3'd1;
  localparam logic [2:0] S_SIGN = 3'd2;
  localparam logic [2:0] S_RD   = 3'd3;
  localparam logic [2:0] S_WR   = 3'd4;
  localparam logic [2:0] S_TERM = 3'd5;

  logic [2:0]       state_q, state_d;
  logic [RW-1:0]    radix_q;
  logic             neg_q, neg_d;
  logic [NDW-1:0]   nd_q, nd_d;
  logic [AW-1:0]    idx_q, idx_d;
  logic             out_valid_q, out_valid_d;
  logic [CW-1:0]    out_char_q, out_char_d;
  logic             out_last_q, out_last_d;

  logic             in_fire;
  logic             radix_ok;
  logic [VALUE_WIDTH-1:0] mag;
  logic             slot_free;

  logic             div_start;
  logic [DIV_W-1:0] div_dividend;
  logic             div_done;
  logic [DIV_W-1:0] div_quo;
  logic [RW-1:0]    div_rem;

  logic             ram_we;
  logic             ram_re;
  logic [RW-1:0]    ram_rdata;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == S_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign radix_ok    = (radix_q >= itoa_pkg::RADIX_MIN) && (radix_q <= itoa_pkg::RADIX_MAX);
  // Two's complement magnitude; the most negative value maps to itself, read unsigned.
  assign mag         = value_i[VALUE_WIDTH-1] ? (~value_i + 1'b1) : value_i;
  assign slot_free   = !out_valid_q || out_ready_i;

  assign div_start    = (in_fire && radix_ok) ||
                        ((state_q == S_DIV) && div_done && (div_quo != '0));
  assign div_dividend = (state_q == S_IDLE) ? DIV_W'(mag) : div_quo;
  assign ram_we       = (state_q == S_DIV) && div_done;
  assign ram_re       = (state_q == S_RD);

  itoa_div #(
    .DIV_W(DIV_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (radix_q),
    .done_o     (div_done),
    .quotient_o (div_quo),
    .remainder_o(div_rem)
  );

  itoa_ram #(
    .WIDTH(RW),
    .DEPTH(VALUE_WIDTH)
  ) u_digits (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(nd_q[AW-1:0]),
    .wdata_i(div_rem),
    .re_i   (ram_re),
    .raddr_i(idx_q),
    .rdata_o(ram_rdata)
  );

  always_comb begin
    state_d     = state_q;
    neg_d       = neg_q;
    nd_d        = nd_q;
    idx_d       = idx_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_char_d  = out_char_q;
    out_last_d  = out_last_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          neg_d   = value_i[VALUE_WIDTH-1];
          nd_d    = '0;
          state_d = radix_ok ? S_DIV : S_TERM;
        end
      end
      S_DIV: begin
        if (div_done) begin
          nd_d = nd_q + 1'b1;
          if (div_quo == '0) begin
            idx_d   = nd_q[AW-1:0];
            state_d = neg_q ? S_SIGN : S_RD;
          end
        end
      end
      S_SIGN: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_char_d  = itoa_pkg::CHAR_MINUS;
          out_last_d  = 1'b0;
          state_d     = S_RD;
        end
      end
      S_RD: begin
        state_d = S_WR;
      end
      S_WR: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_char_d  = itoa_pkg::digit_char(ram_rdata);
          out_last_d  = 1'b0;
          if (idx_q == '0) begin
            state_d = S_TERM;
          end else begin
            idx_d   = idx_q - 1'b1;
            state_d = S_RD;
          end
        end
      end
      S_TERM: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_char_d  = itoa_pkg::CHAR_NUL;
          out_last_d  = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      radix_q     <= itoa_pkg::RADIX_RESET;
      neg_q       <= 1'b0;
      nd_q        <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      neg_q       <= neg_d;
      nd_q        <= nd_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        radix_q <= radix_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_char_q <= out_char_d;
    out_last_q <= out_last_d;
  end

  assign out_valid_o = out_valid_q;
  assign char_out_o  = out_char_q;
  assign last_o      = out_last_q;

endmodule

// ===== hdl/itoa_checker.sv =====
// Port-level checker for integer_to_ascii_radix_core, with its bind.
// Depends on itoa_pkg for the character width.
module itoa_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_o,
  input logic                        out_valid_o,
  input logic                        out_ready_i,
  input logic [itoa_pkg::CHAR_W-1:0] char_out_o,
  input logic                        last_o
);

  // A waiting output word keeps its payload until taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(char_out_o) && $stable(last_o))
    else $error("output word changed while stalled");

  // Every input word produces at least one output word, so the input closes.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input still ready right after a word was taken");

  // Only the terminator carries last, and it is the zero byte.
  a_last_is_nul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_o |-> char_out_o == itoa_pkg::CHAR_NUL)
    else $error("last word is not the zero byte");

  a_body_not_nul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_o |-> char_out_o != itoa_pkg::CHAR_NUL)
    else $error("zero byte emitted without last");

endmodule

bind integer_to_ascii_radix_core itoa_checker u_itoa_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_ready_o (in_ready_o),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .char_out_o (char_out_o),
  .last_o     (last_o)
);
